// ===== sv/bfca_pkg.sv =====
package bfca_pkg;

    // Fixed field widths
    localparam int ADDR_W   = 32;
    localparam int ALIGN_W  = 17;
    localparam int KIND_W   = 3;
    localparam int CFG_IDX_W = 1;

    // Rounded size can exceed 32 bits by one
    localparam int NEED_W   = ADDR_W + 1;

    localparam int DEF_MAX_CHUNKS = 64;
    localparam int DEF_ADDR_BITS  = 32;

    localparam logic [ADDR_W-1:0]  POOL_RESET  = 32'd1048576;
    localparam logic [ALIGN_W-1:0] ALIGN_RESET = 17'd256;

    // Request kinds
    localparam logic [KIND_W-1:0] REQ_ALLOC   = 3'd0;
    localparam logic [KIND_W-1:0] REQ_PRIVATE = 3'd1;
    localparam logic [KIND_W-1:0] REQ_FREE    = 3'd2;
    localparam logic [KIND_W-1:0] REQ_QUERY   = 3'd3;
    localparam logic [KIND_W-1:0] REQ_PEAKS   = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_POOL  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_ALIGN = 1'b1;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_ZERO     = 3'd1,
        ST_NOFIT    = 3'd2,
        ST_FULL     = 3'd3,
        ST_NOTALLOC = 3'd4
    } status_t;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] len;
        logic              used;
    } chunk_t;

endpackage

// ===== sv/bfca_div.sv =====
// Restoring divider, one quotient bit per cycle
module bfca_div
    import bfca_pkg::*;
#(
    parameter int DW = NEED_W,
    parameter int VW = ALIGN_W
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);

    localparam int CW = $clog2(DW + 1);

    logic [VW-1:0] rem_reg;
    logic [DW-1:0] quo_reg;
    logic [VW-1:0] dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic          done_reg;
    logic [VW:0]   trial;
    logic          fits;

    // Trial subtract of the shifted remainder
    assign trial = {rem_reg, quo_reg[DW-1]};
    assign fits  = trial >= {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                cnt_reg <= CW'(DW);
            end
            else if (cnt_reg != '0)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dsr_reg <= divisor;
        end
        else if (cnt_reg != '0)
        begin
            rem_reg <= fits ? VW'(trial - {1'b0, dsr_reg}) : trial[VW-1:0];
            quo_reg <= {quo_reg[DW-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/best_fit_coalescing_allocator.sv =====
// Channel  | Direction | Handshake          | Payload
// cfg      | in        | cfg_we             | cfg_index, cfg_data
// request  | in        | in_valid, in_stall | req_type, request_size, address
// result   | out       | out_valid, out_stall | status, result_address, is_tracked, stats
//
// Allocate: divider, multiply, table scan and decision, then write-back of the entries,
//   or opening a slot and write-back; the chunk memory's single read port sets the pace.
// Free: table scan and decision, then closing the gap and write-back. Query: table
//   scan and decision. Zero size, peak reset and unused kinds are answered in idle.
// Reset needs no clearing pass: entry 0 reads as the whole pool until written.
// One request at a time; a new transaction waits while a result is stalled.
module best_fit_coalescing_allocator
    import bfca_pkg::*;
#(
    parameter int MAX_CHUNKS = DEF_MAX_CHUNKS,
    parameter int ADDR_BITS  = DEF_ADDR_BITS
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [KIND_W-1:0]    req_type,
    input  logic [ADDR_W-1:0]    request_size,
    input  logic [ADDR_W-1:0]    address,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [2:0]           status,
    output logic [ADDR_W-1:0]    result_address,
    output logic                 is_tracked,
    output logic [ADDR_W-1:0]    allocated_bytes,
    output logic [ADDR_W-1:0]    peak_allocated,
    output logic [ADDR_W-1:0]    peak_single,
    output logic [ADDR_W-1:0]    frozen_bytes
);

    localparam int IDX_W = $clog2(MAX_CHUNKS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [63:0] POOL_LIMIT = (64'd1 << ADDR_BITS) - 64'd1;

    typedef enum logic [2:0] {
        S_IDLE, S_DIV, S_MUL, S_SCAN, S_DECIDE, S_INS, S_REM, S_FIX
    } state_t;

    state_t state_reg;

    // Chunk table memory
    chunk_t mem [MAX_CHUNKS];
    chunk_t rd_data_reg;
    logic   rd_ovr_reg;
    logic   ovr_reg;
    logic   wr_en_reg;
    logic [IDX_W-1:0] wr_addr_reg;
    chunk_t wr_data_reg;

    // Configuration and statistics
    logic [ADDR_W-1:0]  pool_reg;
    logic [ALIGN_W-1:0] align_reg;
    logic [ADDR_W-1:0]  frozen_reg;
    logic [ADDR_W-1:0]  total_reg;
    logic [ADDR_W-1:0]  peak_total_reg;
    logic [ADDR_W-1:0]  peak_one_reg;
    logic [CNT_W-1:0]   count_reg;

    // Request in flight
    logic [KIND_W-1:0]  kind_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [NEED_W-1:0]  need_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   eval_reg;
    logic               rv_reg;
    logic               found_reg;
    logic [IDX_W-1:0]   pick_reg;
    chunk_t             pick_d_reg;
    chunk_t             last_d_reg;
    chunk_t             prev_d_reg;
    chunk_t             next_d_reg;
    logic               have_prev_reg;
    logic               have_next_reg;
    logic [CNT_W-1:0]   stop_reg;
    logic [1:0]         k_reg;
    logic               fix_two_reg;
    logic               fix_step_reg;
    logic [IDX_W-1:0]   fix_a_addr_reg;
    chunk_t             fix_a_reg;
    logic [IDX_W-1:0]   fix_b_addr_reg;
    chunk_t             fix_b_reg;
    logic [CNT_W-1:0]   count_new_reg;

    // Result registers
    logic               out_valid_reg;
    status_t            status_reg;
    logic [ADDR_W-1:0]  res_reg;
    logic               tracked_reg;

    // Datapath
    logic               in_take;
    logic [ALIGN_W-1:0] a_eff;
    logic               div_start;
    logic [NEED_W-1:0]  dividend;
    logic               div_done;
    logic [NEED_W-1:0]  div_q;
    logic [NEED_W+ALIGN_W-1:0] product;
    chunk_t             rdat;
    logic               rd_issue;
    logic [IDX_W-1:0]   rd_addr;
    logic [ADDR_W-1:0]  need32;
    logic               split;
    logic [CNT_W-1:0]   p_plus;
    logic               fit_norm;
    logic               fit_priv;
    logic [ADDR_W+1:0]  end_sum;
    logic [ADDR_W-1:0]  new_total;
    logic [ADDR_W-1:0]  priv_res;
    logic               mn;
    logic               mp;
    logic [ADDR_W-1:0]  pool_clamped;

    assign in_stall = (state_reg != S_IDLE) || out_valid_reg;
    assign in_take  = in_valid && !in_stall;

    assign a_eff     = (align_reg == '0) ? ALIGN_W'(1) : align_reg;
    assign dividend  = {1'b0, request_size} + {{(NEED_W-ALIGN_W){1'b0}}, a_eff} - NEED_W'(1);
    assign div_start = in_take && (req_type == REQ_ALLOC || req_type == REQ_PRIVATE)
                       && (request_size != '0);
    assign product   = div_q * a_eff;

    bfca_div #(.DW(NEED_W), .VW(ALIGN_W)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (dividend),
        .divisor  (a_eff),
        .done     (div_done),
        .quotient (div_q)
    );

    // Entry 0 stands for the whole pool until it is first written
    assign rdat = rd_ovr_reg ? chunk_t'{start: '0, len: pool_reg, used: 1'b0} : rd_data_reg;

    // Read port shared by scan and shift
    always_comb
    begin
        unique case (state_reg)
            S_SCAN, S_REM: rd_issue = idx_reg < count_reg;
            S_INS:         rd_issue = idx_reg >= stop_reg;
            default:       rd_issue = 1'b0;
        endcase
    end
    assign rd_addr = idx_reg[IDX_W-1:0];

    always_ff @(posedge clk)
    begin
        if (wr_en_reg)
        begin
            mem[wr_addr_reg] <= wr_data_reg;
        end
        rd_data_reg <= mem[rd_addr];
    end

    // Scan tests and decision arithmetic
    assign need32   = need_reg[ADDR_W-1:0];
    assign end_sum  = {2'b0, rdat.start} + {1'b0, need_reg};
    assign fit_norm = !rdat.used && ({1'b0, rdat.len} >= need_reg)
                      && (end_sum <= {2'b0, frozen_reg})
                      && (!found_reg || rdat.len < pick_d_reg.len);
    assign fit_priv = !rdat.used && ({1'b0, rdat.len} >= need_reg);
    assign split    = pick_d_reg.len != need32;
    assign p_plus   = {1'b0, pick_reg} + CNT_W'(1);
    assign new_total = total_reg + need32;
    assign priv_res = pick_d_reg.start + (pick_d_reg.len - need32);
    assign mn       = have_next_reg && !next_d_reg.used;
    assign mp       = have_prev_reg && !prev_d_reg.used;
    assign pool_clamped = ({32'd0, cfg_data} > POOL_LIMIT) ? POOL_LIMIT[ADDR_W-1:0] : cfg_data;

    // Control sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            pool_reg       <= POOL_RESET;
            align_reg      <= ALIGN_RESET;
            frozen_reg     <= POOL_RESET;
            total_reg      <= '0;
            peak_total_reg <= '0;
            peak_one_reg   <= '0;
            count_reg      <= CNT_W'(1);
            ovr_reg        <= 1'b1;
            out_valid_reg  <= 1'b0;
            wr_en_reg      <= 1'b0;
            rv_reg         <= 1'b0;
        end
        else
        begin
            wr_en_reg  <= 1'b0;
            rv_reg     <= rd_issue;
            rd_ovr_reg <= ovr_reg && (rd_addr == '0);
            if (rd_issue)
            begin
                eval_reg <= idx_reg;
            end
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (cfg_we && cfg_index == CFG_POOL)
                    begin
                        pool_reg       <= pool_clamped;
                        frozen_reg     <= pool_clamped;
                        total_reg      <= '0;
                        peak_total_reg <= '0;
                        peak_one_reg   <= '0;
                        count_reg      <= CNT_W'(1);
                        ovr_reg        <= 1'b1;
                    end
                    else if (cfg_we && cfg_index == CFG_ALIGN)
                    begin
                        align_reg <= cfg_data[ALIGN_W-1:0];
                    end
                    if (in_take)
                    begin
                        kind_reg      <= req_type;
                        addr_reg      <= address;
                        found_reg     <= 1'b0;
                        have_next_reg <= 1'b0;
                        have_prev_reg <= 1'b0;
                        status_reg    <= ST_OK;
                        res_reg       <= '0;
                        tracked_reg   <= 1'b0;
                        idx_reg       <= '0;
                        if (req_type == REQ_ALLOC || req_type == REQ_PRIVATE)
                        begin
                            if (request_size == '0)
                            begin
                                status_reg    <= ST_ZERO;
                                out_valid_reg <= 1'b1;
                            end
                            else
                            begin
                                state_reg <= S_DIV;
                            end
                        end
                        else if (req_type == REQ_FREE || req_type == REQ_QUERY)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            if (req_type == REQ_PEAKS)
                            begin
                                peak_total_reg <= total_reg;
                                peak_one_reg   <= '0;
                            end
                            out_valid_reg <= 1'b1;
                        end
                    end
                end

                S_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_MUL;
                    end
                end

                S_MUL:
                begin
                    need_reg  <= product[NEED_W-1:0];
                    state_reg <= S_SCAN;
                end

                // One entry a cycle; data evaluated in the cycle after its read
                S_SCAN:
                begin
                    if (rd_issue)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    if (rv_reg)
                    begin
                        last_d_reg <= rdat;
                        if ((kind_reg == REQ_ALLOC && fit_norm) ||
                            (kind_reg == REQ_PRIVATE && fit_priv))
                        begin
                            found_reg  <= 1'b1;
                            pick_reg   <= eval_reg[IDX_W-1:0];
                            pick_d_reg <= rdat;
                        end
                        else if (kind_reg == REQ_FREE)
                        begin
                            if (!found_reg && rdat.start == addr_reg)
                            begin
                                found_reg     <= 1'b1;
                                pick_reg      <= eval_reg[IDX_W-1:0];
                                pick_d_reg    <= rdat;
                                prev_d_reg    <= last_d_reg;
                                have_prev_reg <= eval_reg != '0;
                            end
                            else if (found_reg && !have_next_reg && eval_reg == p_plus)
                            begin
                                next_d_reg    <= rdat;
                                have_next_reg <= 1'b1;
                            end
                        end
                        else if (kind_reg == REQ_QUERY)
                        begin
                            if (rdat.start == addr_reg && rdat.used)
                            begin
                                tracked_reg <= 1'b1;
                            end
                        end
                    end
                    if (!rd_issue && !rv_reg)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end

                S_DECIDE:
                begin
                    fix_step_reg <= 1'b0;
                    fix_two_reg  <= 1'b0;
                    state_reg    <= S_IDLE;
                    if (kind_reg == REQ_QUERY)
                    begin
                        out_valid_reg <= 1'b1;
                    end
                    else if (kind_reg == REQ_FREE)
                    begin
                        if (!found_reg || !pick_d_reg.used)
                        begin
                            status_reg    <= ST_NOTALLOC;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            total_reg <= total_reg - pick_d_reg.len;
                            state_reg <= S_FIX;
                            if (mp)
                            begin
                                fix_b_addr_reg <= pick_reg - IDX_W'(1);
                                fix_b_reg      <= chunk_t'{start: prev_d_reg.start,
                                    len: prev_d_reg.len + pick_d_reg.len
                                         + (mn ? next_d_reg.len : '0),
                                    used: 1'b0};
                            end
                            else
                            begin
                                fix_b_addr_reg <= pick_reg;
                                fix_b_reg      <= chunk_t'{start: pick_d_reg.start,
                                    len: pick_d_reg.len + (mn ? next_d_reg.len : '0),
                                    used: 1'b0};
                            end
                            k_reg <= {1'b0, mp} + {1'b0, mn};
                            count_new_reg <= count_reg - CNT_W'(mp) - CNT_W'(mn);
                            idx_reg <= mn ? p_plus + CNT_W'(1) : p_plus;
                            if ((mn || mp) && (mn ? p_plus + CNT_W'(1) : p_plus) < count_reg)
                            begin
                                state_reg <= S_REM;
                            end
                        end
                    end
                    else if (!found_reg)
                    begin
                        status_reg    <= ST_NOFIT;
                        out_valid_reg <= 1'b1;
                    end
                    else if (split && count_reg == CNT_W'(MAX_CHUNKS))
                    begin
                        status_reg    <= ST_FULL;
                        out_valid_reg <= 1'b1;
                    end
                    else
                    begin
                        total_reg <= new_total;
                        if (new_total > peak_total_reg)
                        begin
                            peak_total_reg <= new_total;
                        end
                        if (need32 > peak_one_reg)
                        begin
                            peak_one_reg <= need32;
                        end
                        fix_two_reg    <= split;
                        fix_a_addr_reg <= p_plus[IDX_W-1:0];
                        fix_b_addr_reg <= pick_reg;
                        count_new_reg  <= count_reg + CNT_W'(split);
                        if (kind_reg == REQ_ALLOC)
                        begin
                            res_reg   <= pick_d_reg.start;
                            fix_a_reg <= chunk_t'{start: pick_d_reg.start + need32,
                                len: pick_d_reg.len - need32, used: 1'b0};
                            fix_b_reg <= chunk_t'{start: pick_d_reg.start,
                                len: need32, used: 1'b1};
                        end
                        else if (split)
                        begin
                            res_reg   <= priv_res;
                            fix_a_reg <= chunk_t'{start: priv_res, len: need32, used: 1'b1};
                            fix_b_reg <= chunk_t'{start: pick_d_reg.start,
                                len: pick_d_reg.len - need32, used: 1'b0};
                            if (priv_res < frozen_reg)
                            begin
                                frozen_reg <= priv_res;
                            end
                        end
                        else
                        begin
                            res_reg   <= pick_d_reg.start;
                            fix_b_reg <= chunk_t'{start: pick_d_reg.start,
                                len: pick_d_reg.len, used: 1'b1};
                            if (pick_d_reg.start < frozen_reg)
                            begin
                                frozen_reg <= pick_d_reg.start;
                            end
                        end
                        stop_reg <= p_plus;
                        idx_reg  <= count_reg - CNT_W'(1);
                        if (split && count_reg > p_plus)
                        begin
                            state_reg <= S_INS;
                        end
                        else
                        begin
                            state_reg <= S_FIX;
                        end
                    end
                end

                // Move entries up one slot, top first
                S_INS:
                begin
                    if (rd_issue)
                    begin
                        idx_reg <= idx_reg - CNT_W'(1);
                    end
                    if (rv_reg)
                    begin
                        wr_en_reg   <= 1'b1;
                        wr_addr_reg <= IDX_W'(eval_reg + CNT_W'(1));
                        wr_data_reg <= rdat;
                        if (eval_reg + CNT_W'(1) == '0)
                        begin
                            ovr_reg <= 1'b0;
                        end
                    end
                    if (!rd_issue && !rv_reg)
                    begin
                        state_reg <= S_FIX;
                    end
                end

                // Move entries down by the number of merged chunks
                S_REM:
                begin
                    if (rd_issue)
                    begin
                        idx_reg <= idx_reg + CNT_W'(1);
                    end
                    if (rv_reg)
                    begin
                        wr_en_reg   <= 1'b1;
                        wr_addr_reg <= IDX_W'(eval_reg - CNT_W'(k_reg));
                        wr_data_reg <= rdat;
                        if (eval_reg == CNT_W'(k_reg))
                        begin
                            ovr_reg <= 1'b0;
                        end
                    end
                    if (!rd_issue && !rv_reg)
                    begin
                        state_reg <= S_FIX;
                    end
                end

                // Final entry writes
                S_FIX:
                begin
                    wr_en_reg <= 1'b1;
                    if (fix_two_reg && !fix_step_reg)
                    begin
                        fix_step_reg <= 1'b1;
                        wr_addr_reg  <= fix_a_addr_reg;
                        wr_data_reg  <= fix_a_reg;
                        if (fix_a_addr_reg == '0)
                        begin
                            ovr_reg <= 1'b0;
                        end
                    end
                    else
                    begin
                        wr_addr_reg   <= fix_b_addr_reg;
                        wr_data_reg   <= fix_b_reg;
                        if (fix_b_addr_reg == '0)
                        begin
                            ovr_reg <= 1'b0;
                        end
                        count_reg     <= count_new_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign result_address  = res_reg;
    assign is_tracked      = tracked_reg;
    assign allocated_bytes = total_reg;
    assign peak_allocated  = peak_total_reg;
    assign peak_single     = peak_one_reg;
    assign frozen_bytes    = pool_reg - frozen_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg >= CNT_W'(1) && count_reg <= CNT_W'(MAX_CHUNKS))
        else $error("chunk count out of range");

    a_write_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en_reg |-> {1'b0, wr_addr_reg} <= count_reg)
        else $error("chunk write beyond table end");

    a_total_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        total_reg <= pool_reg && frozen_reg <= pool_reg)
        else $error("statistics exceed pool");

    a_result_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> in_stall)
        else $error("request taken while result pending");
`endif

endmodule

// ===== bench/alloc_checker.sv =====
`timescale 1ns / 100ps

module alloc_checker
    import bfca_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [ADDR_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [KIND_W-1:0]    req_type,
    input  logic [ADDR_W-1:0]    request_size,
    input  logic [ADDR_W-1:0]    address,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [2:0]           status,
    input  logic [ADDR_W-1:0]    result_address,
    input  logic                 is_tracked,
    input  logic [ADDR_W-1:0]    allocated_bytes,
    input  logic [ADDR_W-1:0]    peak_allocated,
    input  logic [ADDR_W-1:0]    peak_single,
    input  logic [ADDR_W-1:0]    frozen_bytes,
    output int                   fail_count,
    output int                   pending
);

    localparam int CHUNKS = DEF_MAX_CHUNKS;

    typedef struct {
        status_t           st;
        logic [ADDR_W-1:0] block_addr;
        logic              tracked;
        logic [ADDR_W-1:0] total;
        logic [ADDR_W-1:0] peak;
        logic [ADDR_W-1:0] peak_one;
        logic [ADDR_W-1:0] frozen;
    } answer_t;

    // Shadow chunk table, held wider than the pool so rounding cannot wrap
    logic [63:0] c_start [CHUNKS];
    logic [63:0] c_len   [CHUNKS];
    bit          c_used  [CHUNKS];
    int          n_chunks;
    logic [63:0] pool_b, align_b, frozen_at, total_b, peak_b, peak1_b;

    answer_t awaited[$];
    int      fails;

    assign fail_count = fails;
    assign pending    = awaited.size();

    function automatic void clear_table();
        for (int i = 0; i < CHUNKS; i++)
        begin
            c_start[i] = 0;
            c_len[i]   = 0;
            c_used[i]  = 0;
        end
        c_len[0]  = pool_b;
        n_chunks  = 1;
        frozen_at = pool_b;
        total_b   = 0;
        peak_b    = 0;
        peak1_b   = 0;
    endfunction

    function automatic void open_slot(int pos, logic [63:0] s, logic [63:0] l, bit u);
        for (int i = n_chunks; i > pos; i--)
        begin
            c_start[i] = c_start[i-1];
            c_len[i]   = c_len[i-1];
            c_used[i]  = c_used[i-1];
        end
        c_start[pos] = s;
        c_len[pos]   = l;
        c_used[pos]  = u;
        n_chunks++;
    endfunction

    function automatic void close_slot(int pos);
        for (int i = pos; i + 1 < n_chunks; i++)
        begin
            c_start[i] = c_start[i+1];
            c_len[i]   = c_len[i+1];
            c_used[i]  = c_used[i+1];
        end
        n_chunks--;
        c_start[n_chunks] = 0;
        c_len[n_chunks]   = 0;
        c_used[n_chunks]  = 0;
    endfunction

    function automatic void book_block(logic [63:0] sz);
        total_b = total_b + sz;
        if (total_b > peak_b) peak_b = total_b;
        if (sz > peak1_b) peak1_b = sz;
    endfunction

    // Apply one request to the shadow table and work out its answer
    function automatic answer_t serve_request(logic [KIND_W-1:0] kind,
                                              logic [63:0] sz, logic [63:0] at);
        answer_t     ans;
        logic [63:0] gran, need, rest;
        int          pick;
        ans.st         = ST_OK;
        ans.block_addr = '0;
        ans.tracked    = 1'b0;
        gran = (align_b == 0) ? 64'd1 : align_b;
        need = ((sz + gran - 1) / gran) * gran;
        pick = -1;
        if (kind == REQ_ALLOC || kind == REQ_PRIVATE)
        begin
            if (sz == 0)
                ans.st = ST_ZERO;
            else
            begin
                if (kind == REQ_ALLOC)
                begin
                    // best fit below the frozen boundary, lowest address on ties
                    for (int i = 0; i < n_chunks; i++)
                        if (!c_used[i] && c_len[i] >= need && c_start[i] + need <= frozen_at
                            && (pick < 0 || c_len[i] < c_len[pick]))
                            pick = i;
                end
                else
                begin
                    // first fit from the top
                    for (int i = n_chunks - 1; i >= 0; i--)
                        if (pick < 0 && !c_used[i] && c_len[i] >= need)
                            pick = i;
                end
                if (pick < 0)
                    ans.st = ST_NOFIT;
                else if (c_len[pick] != need && n_chunks >= CHUNKS)
                    ans.st = ST_FULL;
                else if (kind == REQ_ALLOC)
                begin
                    if (c_len[pick] != need)
                    begin
                        open_slot(pick + 1, c_start[pick] + need, c_len[pick] - need, 0);
                        c_len[pick] = need;
                    end
                    c_used[pick]   = 1;
                    ans.block_addr = c_start[pick][ADDR_W-1:0];
                    book_block(need);
                end
                else
                begin
                    if (c_len[pick] == need)
                    begin
                        c_used[pick] = 1;
                        rest = c_start[pick];
                    end
                    else
                    begin
                        c_len[pick] = c_len[pick] - need;
                        rest = c_start[pick] + c_len[pick];
                        open_slot(pick + 1, rest, need, 1);
                    end
                    ans.block_addr = rest[ADDR_W-1:0];
                    if (rest < frozen_at) frozen_at = rest;
                    book_block(need);
                end
            end
        end
        else if (kind == REQ_FREE)
        begin
            for (int i = 0; i < n_chunks; i++)
                if (pick < 0 && c_start[i] == at)
                    pick = i;
            if (pick < 0 || !c_used[pick])
                ans.st = ST_NOTALLOC;
            else
            begin
                total_b = total_b - c_len[pick];
                c_used[pick] = 0;
                if (pick + 1 < n_chunks && !c_used[pick+1])
                begin
                    c_len[pick] = c_len[pick] + c_len[pick+1];
                    close_slot(pick + 1);
                end
                if (pick > 0 && !c_used[pick-1])
                begin
                    c_len[pick-1] = c_len[pick-1] + c_len[pick];
                    close_slot(pick);
                end
            end
        end
        else if (kind == REQ_QUERY)
        begin
            for (int i = 0; i < n_chunks; i++)
                if (c_start[i] == at && c_used[i])
                    ans.tracked = 1'b1;
        end
        else if (kind == REQ_PEAKS)
        begin
            peak_b  = total_b;
            peak1_b = 0;
        end
        ans.total    = total_b[ADDR_W-1:0];
        ans.peak     = peak_b[ADDR_W-1:0];
        ans.peak_one = peak1_b[ADDR_W-1:0];
        ans.frozen   = pool_b[ADDR_W-1:0] - frozen_at[ADDR_W-1:0];
        return ans;
    endfunction

    function automatic void compare_field(string name, logic [ADDR_W-1:0] want,
                                          logic [ADDR_W-1:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s wrong, expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    // Track configuration, predict on accepted requests, check accepted results
    always @(posedge clk or negedge rst_n)
    begin
        answer_t head;
        if (!rst_n)
        begin
            pool_b  = POOL_RESET;
            align_b = ALIGN_RESET;
            clear_table();
            awaited.delete();
            fails = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_POOL)
                begin
                    pool_b = cfg_data;
                    clear_table();
                end
                else if (cfg_index == CFG_ALIGN)
                    align_b = cfg_data & 32'h1FFFF;
            end
            if (in_valid && !in_stall)
                awaited.insert(awaited.size(),
                               serve_request(req_type, request_size, address));
            if (out_valid && !out_stall)
            begin
                if (awaited.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result transaction, status %0d",
                             $time, status);
                end
                else
                begin
                    head = awaited.pop_front();
                    compare_field("status", ADDR_W'(head.st), ADDR_W'(status));
                    compare_field("result_address", head.block_addr, result_address);
                    compare_field("is_tracked", ADDR_W'(head.tracked), ADDR_W'(is_tracked));
                    compare_field("allocated_bytes", head.total, allocated_bytes);
                    compare_field("peak_allocated", head.peak, peak_allocated);
                    compare_field("peak_single", head.peak_one, peak_single);
                    compare_field("frozen_bytes", head.frozen, frozen_bytes);
                end
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb
    import bfca_pkg::*;
();

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_POOL;
    logic [ADDR_W-1:0]    cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic [KIND_W-1:0]    req_type = REQ_QUERY;
    logic [ADDR_W-1:0]    request_size = '0;
    logic [ADDR_W-1:0]    address = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [2:0]           status;
    logic [ADDR_W-1:0]    result_address;
    logic                 is_tracked;
    logic [ADDR_W-1:0]    allocated_bytes;
    logic [ADDR_W-1:0]    peak_allocated;
    logic [ADDR_W-1:0]    peak_single;
    logic [ADDR_W-1:0]    frozen_bytes;
    int                   fail_count;
    int                   pending;

    bit hold_req  = 0;
    bit hold_used = 0;
    int sent      = 0;

    // Pool, alignment and size cap per phase; cap 0 means a sixth of the pool
    logic [31:0] pools  [6] = '{32'd4096, 32'd0, 32'd65536, 32'hFFFFFFFF, 32'd1000,
                                32'd1048576};
    logic [31:0] aligns [6] = '{32'd256, 32'd0, 32'd1, 32'd65536, 32'd7, 32'd4096};
    logic [31:0] caps   [6] = '{32'd1024, 32'd64, 32'd16, 32'd0, 32'd300, 32'd65536};

    always #5 clk = ~clk;

    best_fit_coalescing_allocator dut (.*);

    alloc_checker chk (.*);

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Offer one request and hold it until accepted; valid stays high afterwards
    task automatic offer(logic [KIND_W-1:0] kind, logic [31:0] sz, logic [31:0] at);
        in_valid     <= 1'b1;
        req_type     <= kind;
        request_size <= sz;
        address      <= at;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sent++;
    endtask

    task automatic gap(int cycles);
        in_valid <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    task automatic drain();
        gap(1);
        wait (pending == 0);
        repeat (250) @(posedge clk);
    endtask

    // Receiver stall pattern, with one long hold-off on request
    initial
    begin
        int mode;
        forever
        begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(20, 80))
            begin
                @(posedge clk);
                if (hold_req && !hold_used)
                begin
                    hold_used = 1;
                    out_stall <= 1'b1;
                    repeat (400) @(posedge clk);
                end
                else if (mode == 0)
                    out_stall <= 1'b0;
                else if (mode == 1)
                    out_stall <= ($urandom_range(0, 3) == 0);
                else
                    out_stall <= ($urandom_range(0, 9) < 7);
            end
        end
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [31:0] gran, cap, sz, at;
        int          burst, pick;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: defaults of 1 MiB pool, 256-byte alignment
        offer(REQ_ALLOC, 32'd0, 32'd0);
        offer(REQ_PRIVATE, 32'd0, 32'd0);
        offer(REQ_ALLOC, 32'd1, 32'd0);
        offer(REQ_ALLOC, 32'hFFFFFFFF, 32'hFFFFFFFF);
        offer(REQ_PRIVATE, 32'hFFFFFFFF, 32'd0);
        offer(REQ_PRIVATE, 32'h1000, 32'd0);
        offer(REQ_ALLOC, 32'h100000, 32'd0);
        offer(REQ_ALLOC, 32'h300, 32'd0);
        offer(REQ_QUERY, 32'd0, 32'd0);
        offer(REQ_QUERY, 32'd0, 32'h100);
        offer(REQ_QUERY, 32'hFFFFFFFF, 32'hFFFFFFFF);
        offer(REQ_FREE, 32'd0, 32'd0);
        offer(REQ_FREE, 32'd0, 32'd0);
        offer(REQ_FREE, 32'd0, 32'h12345);
        offer(REQ_FREE, 32'd0, 32'hFFFFFFFF);
        offer(REQ_ALLOC, 32'h100, 32'd0);
        offer(REQ_PEAKS, 32'd0, 32'd0);
        offer(3'd5, 32'hFFFFFFFF, 32'hFFFFFFFF);
        offer(3'd6, 32'd0, 32'd0);
        offer(3'd7, 32'd0, 32'd0);
        offer(REQ_FREE, 32'd0, 32'h100);
        offer(REQ_FREE, 32'd0, 32'hFF000);
        drain();

        // Random phases, each under a fresh pool and alignment
        for (int ph = 0; ph < 6; ph++)
        begin
            write_reg(CFG_ALIGN, aligns[ph]);
            write_reg(CFG_POOL, pools[ph]);
            gran = (aligns[ph] == 0) ? 32'd1 : aligns[ph];
            cap  = (caps[ph] != 0) ? caps[ph] : pools[ph] / 6;
            if (cap == 0) cap = 1;
            burst = 0;
            for (int n = 0; n < 90; n++)
            begin
                if (ph == 0 && n == 20) hold_req = 1;
                if (ph == 0 && n == 45)
                begin
                    gap(1);
                    wait (pending == 0);
                end
                if (burst == 0)
                begin
                    gap($urandom_range(1, 12));
                    burst = $urandom_range(1, 15);
                end
                burst--;
                pick = $urandom_range(0, 19);
                sz = (pick == 0) ? 32'd0 : (pick == 1) ? $urandom : $urandom_range(1, cap);
                pick = $urandom_range(0, 9);
                if (pick < 4)
                    at = $urandom_range(0, 15) * gran;
                else if (pick < 8)
                    at = pools[ph] - $urandom_range(1, 16) * gran;
                else
                    at = $urandom;
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    offer(REQ_ALLOC, sz, at);
                else if (pick < 55)
                    offer(REQ_PRIVATE, sz, at);
                else if (pick < 85)
                    offer(REQ_FREE, sz, at);
                else if (pick < 95)
                    offer(REQ_QUERY, sz, at);
                else if (pick < 98)
                    offer(REQ_PEAKS, sz, at);
                else
                    offer(3'($urandom_range(5, 7)), sz, at);
            end
            drain();
        end

        $display("Run covered %0d requests over the reset setting and 6 pool/alignment",
                 sent);
        $display("settings, including zero and full-width pools and a full chunk table.");
        if (fail_count == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
